// ===== hw/rtl/dsw_pkg.sv =====
// ----------------------------------------------------------------------------
// dsw_pkg
// shared types and constants of the delay and weekly switch scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package dsw_pkg;

   localparam int DELAY_SLOTS_DEF  = 2;
   localparam int WEEKLY_SLOTS_DEF = 12;
   localparam int MINUTE_SECS      = 60;
   localparam int GRACE_SECS       = 5;
   localparam int TIME_W           = 32;

   localparam logic [1:0] ACT_TICK      = 2'd0;
   localparam logic [1:0] ACT_WR_DELAY  = 2'd1;
   localparam logic [1:0] ACT_WR_WEEKLY = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [15:0]       length;
      logic              turn_on;
      logic              enable;
   } dly_entry_type;

   typedef struct packed {
      logic [6:0]  days;
      logic [15:0] minute;
      logic        turn_on;
      logic        enable;
   } wk_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dsw_mod60.sv =====
// ----------------------------------------------------------------------------
// dsw_mod60
// remainder of a 32-bit time by sixty, registered in the cycle after start
// ----------------------------------------------------------------------------
`default_nettype none

module dsw_mod60
   import dsw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] value,
   output logic                   done,
   output logic [5:0]             remainder
);

   localparam int NIBBLES = TIME_W / 4;
   localparam int LOW_MOD = MINUTE_SECS / 4;

   logic              done_ff;
   logic [5:0]        rem_ff;
   logic [6:0]        nib_sum_in;
   logic [4:0]        fold_in;
   logic [3:0]        mod15_in;
   logic [1:0]        lift_in;
   logic [5:0]        rem_in;

   // sixteen is one modulo fifteen, so nibble sums keep the residue;
   // the residues modulo four and fifteen are then joined
   always_comb begin
      nib_sum_in = '0;
      for (int i = 0; i < NIBBLES; i++) begin
         nib_sum_in = nib_sum_in + 7'(value[4*i +: 4]);
      end
      fold_in  = 5'(nib_sum_in[6:4]) + 5'(nib_sum_in[3:0]);
      mod15_in = (fold_in >= 5'(LOW_MOD)) ? 4'(fold_in - 5'(LOW_MOD)) : fold_in[3:0];
      lift_in  = mod15_in[1:0] - value[1:0];
      rem_in   = 6'(mod15_in) + 6'(lift_in) * 6'(LOW_MOD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (start) begin
         done_ff <= 1'b1;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/delay_and_weekly_switch_scheduler.sv =====
// ----------------------------------------------------------------------------
// delay_and_weekly_switch_scheduler
// one-shot delay slots and weekly slots held in two slot memories
// ----------------------------------------------------------------------------
// write transaction: accept, then ST_WRITE and ST_OUT; one transaction at a time
// tick transaction: accept, then the slot walk (one slot read per cycle,
//   14 slots), drain, finish and output; a new request waits for idle
// delay-only tick skips the weekly walk and goes from the delay walk to drain
// reset clears control, slot valid bits and the delay-only flag; slot memory
//   contents are not cleared, a slot without its valid bit reads as disabled
`default_nettype none

module delay_and_weekly_switch_scheduler
   import dsw_pkg::*;
#(
   parameter int DELAY_SLOTS  = DELAY_SLOTS_DEF,
   parameter int WEEKLY_SLOTS = WEEKLY_SLOTS_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_action,
   input  wire logic [3:0]        req_slot,
   input  wire logic [TIME_W-1:0] req_now_utc,
   input  wire logic [2:0]        req_weekday,
   input  wire logic [16:0]       req_second_of_day,
   input  wire logic [TIME_W-1:0] req_start_utc,
   input  wire logic [15:0]       req_minutes,
   input  wire logic [6:0]        req_day_mask,
   input  wire logic              req_enable,
   input  wire logic              req_turn_on,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_fire,
   output logic                   rsp_switch_on,
   output logic [5:0]             rsp_wait_seconds,
   output logic                   rsp_delay_only
);

   localparam int DIDX_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
   localparam int WIDX_W = (WEEKLY_SLOTS > 1) ? $clog2(WEEKLY_SLOTS) : 1;
   localparam int REM_W  = TIME_W + 3;
   localparam int DMIN_W = TIME_W + 1;
   localparam int LATE_W = 23;
   localparam int PROD_W = 22;
   localparam logic signed [REM_W-1:0]  DLY_LATE_LIM = -REM_W'(GRACE_SECS);
   localparam logic signed [LATE_W-1:0] WK_LATE_LIM  = LATE_W'(GRACE_SECS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_WRITE, ST_DWALK, ST_WWALK, ST_DRAIN, ST_FIN, ST_OUT
   } state_type;

   typedef enum logic [1:0] {EV_NONE, EV_DLY, EV_WK} ev_type;

   state_type         state_ff;
   ev_type            ev_kind_ff;
   logic [DIDX_W-1:0] d_idx_ff;
   logic [WIDX_W-1:0] w_idx_ff;
   logic [DIDX_W-1:0] ev_didx_ff;
   logic [WIDX_W-1:0] ev_widx_ff;

   dly_entry_type     dly_mem [DELAY_SLOTS];
   wk_entry_type      wk_mem  [WEEKLY_SLOTS];
   dly_entry_type     dly_rdata_ff;
   wk_entry_type      wk_rdata_ff;
   logic [DELAY_SLOTS-1:0]  dly_vld_ff;
   logic [WEEKLY_SLOTS-1:0] wk_vld_ff;

   logic [1:0]        action_ff;
   logic [3:0]        slot_ff;
   logic [TIME_W-1:0] now_ff;
   logic [2:0]        wday_ff;
   logic [16:0]       sod_ff;
   logic [TIME_W-1:0] start_ff;
   logic [15:0]       minutes_ff;
   logic [6:0]        mask_ff;
   logic              enable_ff;
   logic              turn_on_ff;

   logic              skip_ff;
   logic              fire_ff;
   logic              on_ff;
   logic              have_ff;
   logic [DMIN_W-1:0] dmin_ff;

   logic              rsp_valid_ff;
   logic              res_fire_ff;
   logic              res_on_ff;
   logic [5:0]        res_wait_ff;
   logic              res_skip_ff;
   logic              out_fire_ff;
   logic              out_on_ff;
   logic [5:0]        out_wait_ff;
   logic              out_skip_ff;

   logic              accept;
   logic              mod_start;
   logic              mod_done;
   logic [5:0]        mod_rem;
   logic              dly_we;
   logic              wk_we;
   logic [PROD_W-1:0] dly_len60_in;
   logic signed [REM_W-1:0]  dly_rem_in;
   logic [PROD_W-1:0] wk_min60_in;
   logic signed [LATE_W-1:0] wk_late_in;
   logic [7:0]        wk_days8_in;
   logic              dly_en_in;
   logic              wk_en_in;
   logic [6:0]        tick_t_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign mod_start = accept && (req_action == ACT_TICK);

   dsw_mod60 u_mod60 (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .value     (req_now_utc),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign dly_we = (state_ff == ST_WRITE) && (action_ff == ACT_WR_DELAY)
                   && (32'(slot_ff) < 32'(DELAY_SLOTS));
   assign wk_we  = (state_ff == ST_WRITE) && (action_ff == ACT_WR_WEEKLY)
                   && (32'(slot_ff) < 32'(WEEKLY_SLOTS));

   // slot memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[DIDX_W'(slot_ff)] <= '{start: start_ff, length: minutes_ff,
                                        turn_on: turn_on_ff, enable: enable_ff};
      end
      dly_rdata_ff <= dly_mem[d_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (wk_we) begin
         wk_mem[WIDX_W'(slot_ff)] <= '{days: mask_ff, minute: minutes_ff,
                                       turn_on: turn_on_ff, enable: enable_ff};
      end
      wk_rdata_ff <= wk_mem[w_idx_ff];
   end

   always_comb begin
      dly_len60_in = PROD_W'(dly_rdata_ff.length) * PROD_W'(MINUTE_SECS);
      dly_rem_in   = REM_W'(dly_rdata_ff.start) + REM_W'(dly_len60_in)
                     - REM_W'(now_ff);
      dly_en_in    = dly_vld_ff[ev_didx_ff] && dly_rdata_ff.enable;
      wk_min60_in  = PROD_W'(wk_rdata_ff.minute) * PROD_W'(MINUTE_SECS);
      wk_late_in   = LATE_W'(sod_ff) - LATE_W'(wk_min60_in);
      wk_days8_in  = {1'b0, wk_rdata_ff.days};
      wk_en_in     = wk_vld_ff[ev_widx_ff] && wk_rdata_ff.enable
                     && wk_days8_in[wday_ff];
      tick_t_in    = 7'(MINUTE_SECS) - 7'(mod_rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_kind_ff   <= EV_NONE;
         dly_vld_ff   <= '0;
         wk_vld_ff    <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         // slot evaluation, in the cycle after the memory read
         unique case (ev_kind_ff)
            EV_DLY: begin
               if (dly_en_in) begin
                  if (dly_rem_in <= REM_W'(0)) begin
                     if (dly_rem_in > DLY_LATE_LIM) begin
                        fire_ff <= 1'b1;
                        on_ff   <= dly_rdata_ff.turn_on;
                     end
                     dly_vld_ff[ev_didx_ff] <= 1'b0;
                  end else if (!have_ff || (dly_rem_in[DMIN_W-1:0] < dmin_ff)) begin
                     dmin_ff <= dly_rem_in[DMIN_W-1:0];
                     have_ff <= 1'b1;
                  end
               end
            end
            EV_WK: begin
               if (wk_en_in && (wk_late_in >= LATE_W'(0)) && (wk_late_in < WK_LATE_LIM)) begin
                  fire_ff <= 1'b1;
                  on_ff   <= wk_rdata_ff.turn_on;
               end
            end
            default: begin
            end
         endcase

         unique case (state_ff)
            ST_IDLE: begin
               ev_kind_ff <= EV_NONE;
               if (accept) begin
                  action_ff  <= req_action;
                  slot_ff    <= req_slot;
                  now_ff     <= req_now_utc;
                  wday_ff    <= req_weekday;
                  sod_ff     <= req_second_of_day;
                  start_ff   <= req_start_utc;
                  minutes_ff <= req_minutes;
                  mask_ff    <= req_day_mask;
                  enable_ff  <= req_enable;
                  turn_on_ff <= req_turn_on;
                  fire_ff    <= 1'b0;
                  on_ff      <= 1'b0;
                  have_ff    <= 1'b0;
                  d_idx_ff   <= '0;
                  w_idx_ff   <= '0;
                  state_ff   <= (req_action == ACT_TICK) ? ST_DWALK : ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (dly_we) begin
                  dly_vld_ff[DIDX_W'(slot_ff)] <= 1'b1;
               end
               if (wk_we) begin
                  wk_vld_ff[WIDX_W'(slot_ff)] <= 1'b1;
               end
               res_fire_ff <= 1'b0;
               res_on_ff   <= 1'b0;
               res_wait_ff <= '0;
               res_skip_ff <= skip_ff;
               state_ff    <= ST_OUT;
            end
            ST_DWALK: begin
               ev_kind_ff <= EV_DLY;
               ev_didx_ff <= d_idx_ff;
               d_idx_ff   <= d_idx_ff + 1'b1;
               if (d_idx_ff == DIDX_W'(DELAY_SLOTS - 1)) begin
                  state_ff <= skip_ff ? ST_DRAIN : ST_WWALK;
               end
            end
            ST_WWALK: begin
               ev_kind_ff <= EV_WK;
               ev_widx_ff <= w_idx_ff;
               w_idx_ff   <= w_idx_ff + 1'b1;
               if (w_idx_ff == WIDX_W'(WEEKLY_SLOTS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               ev_kind_ff <= EV_NONE;
               state_ff   <= ST_FIN;
            end
            ST_FIN: begin
               ev_kind_ff <= EV_NONE;
               if (mod_done) begin
                  res_fire_ff <= fire_ff;
                  res_on_ff   <= fire_ff && on_ff;
                  if (have_ff && (dmin_ff < DMIN_W'(tick_t_in))) begin
                     skip_ff     <= 1'b1;
                     res_skip_ff <= 1'b1;
                     res_wait_ff <= dmin_ff[5:0];
                  end else begin
                     skip_ff     <= 1'b0;
                     res_skip_ff <= 1'b0;
                     res_wait_ff <= tick_t_in[5:0];
                  end
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               ev_kind_ff <= EV_NONE;
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_fire_ff  <= res_fire_ff;
                  out_on_ff    <= res_on_ff;
                  out_wait_ff  <= res_wait_ff;
                  out_skip_ff  <= res_skip_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fire         = out_fire_ff;
   assign rsp_switch_on    = out_on_ff;
   assign rsp_wait_seconds = out_wait_ff;
   assign rsp_delay_only   = out_skip_ff;

endmodule

`default_nettype wire
